// ===== src/mfrq_pkg.sv =====
`timescale 1ns / 1ps

package mfrq_pkg;

   // Defaults for the top-level parameters.
   localparam int DEFAULT_THREADS       = 32;
   localparam int DEFAULT_PREDICT_WIDTH = 16;

   // Reset values of the configuration registers.
   localparam logic [15:0] AGING_THRESHOLD_RST = 16'd1500;
   localparam logic [7:0]  AGING_INCREMENT_RST = 8'd10;

   // Priority bands.
   localparam logic [7:0] PRIO_MAX   = 8'd149;
   localparam logic [7:0] PRIO_LIMIT = 8'd150;
   localparam logic [7:0] LEVEL1_MIN = 8'd100;
   localparam logic [7:0] LEVEL2_MIN = 8'd50;

   // Register indexes on the configuration port.
   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic REG_INCREMENT = 1'b1;

   // Queue levels; zero means the slot is not queued.
   localparam logic [1:0] LVL_NONE  = 2'd0;
   localparam logic [1:0] LVL_ONE   = 2'd1;
   localparam logic [1:0] LVL_TWO   = 2'd2;
   localparam logic [1:0] LVL_THREE = 2'd3;

   // Operation codes of a request.
   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_PICK    = 2'd1,
      OP_AGE     = 2'd2,
      OP_PREEMPT = 2'd3
   } op_type;

   // Bit positions of the result fields in rsp_tdata.
   localparam int RSP_VALID_BIT   = 5;
   localparam int RSP_PREEMPT_BIT = 6;

   // Queue level that a priority belongs to.
   function automatic logic [1:0] level_of(input logic [7:0] prio);
      logic [1:0] lvl;
      if (prio >= LEVEL1_MIN) lvl = LVL_ONE;
      else if (prio >= LEVEL2_MIN) lvl = LVL_TWO;
      else lvl = LVL_THREE;
      return lvl;
   endfunction

endpackage

// ===== src/multilevel_feedback_ready_queue_core.sv =====
`timescale 1ns / 1ps

// Channel    Dir   Contents
// req_       in    tuser: op; tdata: thread_id, priority_req, predict_time, now,
//                  current_priority, current_predict
// rsp_       out   tdata: picked_thread, picked_valid, preempt_request
// csr_       in    APB registers: aging_threshold at 0x0, aging_increment at 0x4
//
// All thread records live in one memory with a registered read. Enqueue reads
// the slot, then writes it if thread and priority are in range. Pick and
// preempt check scan every slot through the memory read port. An aging pass
// repeats that scan once per queued thread plus once more. Reset is synchronous
// and needs no clearing pass.
// A request is taken only in idle; a held result stalls the next completion.

module multilevel_feedback_ready_queue_core
   import mfrq_pkg::*;
#(
   parameter int THREADS       = DEFAULT_THREADS,
   parameter int PREDICT_WIDTH = DEFAULT_PREDICT_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] thread_id, [12:5] priority_req, [28:13] predict_time,
   // [60:29] now, [68:61] current_priority, [84:69] current_predict
   input  logic [87:0] req_tdata,
   // [1:0] op
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [4:0] picked_thread, [5] picked_valid, [6] preempt_request
   output logic [7:0]  rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IW = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int CW = $clog2(THREADS + 1);
   localparam int PW = PREDICT_WIDTH;

   typedef struct packed {
      logic [1:0]    level;
      logic [7:0]    prio;
      logic [PW-1:0] predict;
      logic [31:0]   ready_since;
      logic [31:0]   waited;
      logic [15:0]   arrival;
   } entry_type;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_ENQ_RD = 10'b0000000010,
      ST_ENQ_WR = 10'b0000000100,
      ST_SCAN   = 10'b0000001000,
      ST_PK_SUB = 10'b0000010000,
      ST_PK_WR  = 10'b0000100000,
      ST_AG_SUB = 10'b0001000000,
      ST_AG_SUM = 10'b0010000000,
      ST_AG_WR  = 10'b0100000000,
      ST_FINISH = 10'b1000000000
   } state_type;

   // Fits a 16-bit burst value into the stored predict width.
   function automatic logic [PW-1:0] pred_fit(input logic [15:0] v);
      logic [31:0] wide;
      wide = 32'(v);
      return wide[PW-1:0];
   endfunction

   // True when entry a (lower slot number) is served before entry b.
   function automatic logic goes_first(input entry_type a, input entry_type b,
                                       input logic [15:0] ctr);
      logic [15:0] age_a;
      logic [15:0] age_b;
      logic        res;
      age_a = ctr - a.arrival;
      age_b = ctr - b.arrival;
      if (a.level != b.level) res = a.level < b.level;
      else if (a.level == LVL_ONE && a.predict != b.predict) res = a.predict < b.predict;
      else if (a.level == LVL_TWO && a.prio != b.prio) res = a.prio > b.prio;
      else res = age_a >= age_b;
      return res;
   endfunction

   state_type         state_ff, state_in;
   op_type            op_ff;
   logic [4:0]        tid_ff;
   logic [7:0]        pri_ff;
   logic [PW-1:0]     pred_ff;
   logic [31:0]       now_ff;
   logic [7:0]        cur_pri_ff;
   logic [PW-1:0]     cur_pred_ff;
   logic [15:0]       thr_ff;
   logic [7:0]        inc_ff;
   logic [15:0]       ctr_ff;
   logic [THREADS-1:0] touched_ff;
   logic [THREADS-1:0] visited_ff;
   logic [CW-1:0]     issue_ff;
   logic              rd_valid_ff;
   logic [IW-1:0]     rd_idx_ff;
   logic              best_valid_ff;
   logic [IW-1:0]     best_idx_ff;
   entry_type         best_ff;
   logic [31:0]       diff_ff;
   logic [31:0]       total_ff;
   logic              preempt_ff;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_data_ff;
   logic [7:0]        rsp_data_in;

   entry_type         entry_mem [THREADS];
   entry_type         mem_q_ff;
   logic [IW-1:0]     rd_addr;
   logic              mem_we;
   logic [IW-1:0]     mem_wa;
   entry_type         mem_wd;

   logic              req_take;
   logic              csr_wr;
   logic [31:0]       tid_ext;
   logic [IW-1:0]     tid_idx;
   logic              enq_ok;
   logic              scan_issue;
   logic              scan_done;
   entry_type         cand;
   logic              cand_ok;
   logic              take;
   logic              pre_hit;
   logic [8:0]        np_sum;
   logic [7:0]        np;
   logic [1:0]        np_lvl;
   logic              age_hit;
   logic [31:0]       best_ext;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_INCREMENT) ? 32'(inc_ff) : 32'(thr_ff);

   assign tid_ext = 32'(tid_ff);
   assign tid_idx = tid_ext[IW-1:0];
   assign enq_ok  = (tid_ext < 32'(THREADS)) && (pri_ff < PRIO_LIMIT);

   // Scan bookkeeping: one slot address issued per cycle.
   assign scan_issue = (state_ff == ST_SCAN) && (issue_ff != CW'(THREADS));
   assign scan_done  = (state_ff == ST_SCAN) && !scan_issue && !rd_valid_ff;
   assign rd_addr    = (state_ff == ST_ENQ_RD) ? tid_idx : issue_ff[IW-1:0];

   // Candidate from the memory; untouched slots read as not queued.
   always_comb begin
      cand = mem_q_ff;
      if (!touched_ff[rd_idx_ff]) begin
         cand.level = LVL_NONE;
      end
   end

   assign cand_ok = rd_valid_ff && (cand.level != LVL_NONE)
                    && !(op_ff == OP_AGE && visited_ff[rd_idx_ff]);
   assign take    = cand_ok && (!best_valid_ff || !goes_first(best_ff, cand, ctr_ff));
   assign pre_hit = cand_ok && (cand.level == LVL_ONE) && (cur_pri_ff >= LEVEL1_MIN)
                    && (cur_pred_ff > cand.predict);

   // Aging update for the selected slot.
   assign np_sum  = 9'(best_ff.prio) + 9'(inc_ff);
   assign np      = (np_sum > 9'(PRIO_MAX)) ? PRIO_MAX : np_sum[7:0];
   assign np_lvl  = level_of(np);
   assign age_hit = total_ff >= 32'(thr_ff);
   assign best_ext = 32'(best_idx_ff);

   // Memory write port.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = best_idx_ff;
      mem_wd = best_ff;
      case (state_ff)
         ST_ENQ_WR: begin
            mem_we             = 1'b1;
            mem_wa             = tid_idx;
            mem_wd.level       = level_of(pri_ff);
            mem_wd.prio        = pri_ff;
            mem_wd.predict     = pred_ff;
            mem_wd.ready_since = now_ff;
            mem_wd.waited      = touched_ff[tid_idx] ? mem_q_ff.waited : 32'd0;
            mem_wd.arrival     = ctr_ff;
         end
         ST_PK_WR: begin
            mem_we        = 1'b1;
            mem_wd.level  = LVL_NONE;
            mem_wd.waited = best_ff.waited + diff_ff;
         end
         ST_AG_WR: begin
            mem_we             = age_hit;
            mem_wd.level       = np_lvl;
            mem_wd.prio        = np;
            mem_wd.ready_since = now_ff;
            mem_wd.waited      = total_ff - 32'(thr_ff);
            mem_wd.arrival     = ctr_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Thread record memory with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= entry_mem[rd_addr];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (op_type'(req_tuser) == OP_ENQUEUE) state_in = ST_ENQ_RD;
               else state_in = ST_SCAN;
            end
         end
         ST_ENQ_RD: begin
            state_in = enq_ok ? ST_ENQ_WR : ST_FINISH;
         end
         ST_ENQ_WR: begin
            state_in = ST_FINISH;
         end
         ST_SCAN: begin
            if (scan_done) begin
               if (op_ff == OP_PICK && best_valid_ff) state_in = ST_PK_SUB;
               else if (op_ff == OP_AGE && best_valid_ff) state_in = ST_AG_SUB;
               else state_in = ST_FINISH;
            end
         end
         ST_PK_SUB: begin
            state_in = ST_PK_WR;
         end
         ST_PK_WR: begin
            state_in = ST_FINISH;
         end
         ST_AG_SUB: begin
            state_in = ST_AG_SUM;
         end
         ST_AG_SUM: begin
            state_in = ST_AG_WR;
         end
         ST_AG_WR: begin
            state_in = ST_SCAN;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result payload assembled from the finished request.
   always_comb begin
      rsp_data_in = 8'd0;
      if (op_ff == OP_PICK && best_valid_ff) begin
         rsp_data_in[4:0]           = best_ext[4:0];
         rsp_data_in[RSP_VALID_BIT] = 1'b1;
      end
      rsp_data_in[RSP_PREEMPT_BIT] = preempt_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         thr_ff        <= AGING_THRESHOLD_RST;
         inc_ff        <= AGING_INCREMENT_RST;
         ctr_ff        <= 16'd0;
         touched_ff    <= '0;
         visited_ff    <= '0;
         issue_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
         preempt_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         // Register writes.
         if (csr_wr) begin
            if (csr_paddr[2] == REG_INCREMENT) inc_ff <= csr_pwdata[7:0];
            else thr_ff <= csr_pwdata[15:0];
         end

         // A new request clears the per-request scan state.
         if (req_take) begin
            visited_ff    <= '0;
            issue_ff      <= '0;
            rd_valid_ff   <= 1'b0;
            best_valid_ff <= 1'b0;
            preempt_ff    <= 1'b0;
         end

         // Scan pipeline.
         if (state_ff == ST_SCAN) begin
            rd_valid_ff <= scan_issue;
            if (scan_issue) issue_ff <= issue_ff + CW'(1);
            if (take) best_valid_ff <= 1'b1;
            if (op_ff == OP_PREEMPT && pre_hit) preempt_ff <= 1'b1;
            if (scan_done && op_ff == OP_AGE && best_valid_ff) begin
               visited_ff[best_idx_ff] <= 1'b1;
            end
         end

         // Enqueue stamps the slot.
         if (state_ff == ST_ENQ_WR) begin
            touched_ff[tid_idx] <= 1'b1;
            ctr_ff              <= ctr_ff + 16'd1;
         end

         // Aging requeue, then restart the scan for the next slot.
         if (state_ff == ST_AG_WR) begin
            if (age_hit) begin
               ctr_ff <= ctr_ff + 16'd1;
               if (np_lvl == LVL_ONE) begin
                  if (cur_pri_ff < LEVEL1_MIN || cur_pred_ff > best_ff.predict) begin
                     preempt_ff <= 1'b1;
                  end
               end else if (np_lvl == LVL_TWO) begin
                  if (cur_pri_ff < LEVEL2_MIN) preempt_ff <= 1'b1;
               end
            end
            issue_ff      <= '0;
            rd_valid_ff   <= 1'b0;
            best_valid_ff <= 1'b0;
         end

         // Output register.
         if (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff       <= op_type'(req_tuser);
         tid_ff      <= req_tdata[4:0];
         pri_ff      <= req_tdata[12:5];
         pred_ff     <= pred_fit(req_tdata[28:13]);
         now_ff      <= req_tdata[60:29];
         cur_pri_ff  <= req_tdata[68:61];
         cur_pred_ff <= pred_fit(req_tdata[84:69]);
      end
      if (state_ff == ST_SCAN) begin
         rd_idx_ff <= issue_ff[IW-1:0];
         if (take) begin
            best_ff     <= cand;
            best_idx_ff <= rd_idx_ff;
         end
      end
      if (state_ff == ST_PK_SUB || state_ff == ST_AG_SUB) begin
         diff_ff <= now_ff - best_ff.ready_since;
      end
      if (state_ff == ST_AG_SUM) begin
         total_ff <= diff_ff + best_ff.waited;
      end
      if (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== src/mfrq_checker.sv =====
`timescale 1ns / 1ps

module mfrq_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       csr_pready
);
   import mfrq_pkg::*;

   // After reset no result is offered.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // A result without a valid pick reports slot zero.
   a_pick_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[RSP_VALID_BIT] |-> rsp_tdata[4:0] == 5'd0)
      else $error("slot reported without a valid pick");

   // A pick never asks for preemption.
   a_pick_no_preempt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_VALID_BIT] |-> !rsp_tdata[RSP_PREEMPT_BIT])
      else $error("pick result carries a preempt request");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // The register port never waits.
   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port not ready");

endmodule

bind multilevel_feedback_ready_queue_core mfrq_checker u_mfrq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
